@@ rtl/alt_pkg.sv @@
`timescale 1ns / 1ps

package alt_pkg;

    // Default number of instruction slots per line.
    localparam int SLOTS_DEF = 3;

    // Register digits '0' up to '0' + REGISTER_COUNT - 1 continue a register token.
    localparam int REGISTER_COUNT = 4;

    // Character codes.
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_DIGIT_0 = 8'd48;
    localparam logic [7:0] CH_DIGIT_9 = 8'd57;
    localparam logic [7:0] CH_REG     = 8'd82;

    // Word buffer holds four characters, first character in the top byte.
    localparam int          WORD_DEPTH = 4;
    localparam logic [2:0]  WORD_SAT   = 3'd5;
    localparam int          MNEMONICS  = 18;
    localparam logic [31:0] WORD_JZ    = {"JZ", 16'h0000};
    localparam logic [31:0] VALUE_JZ   = 32'hFFFF_FFFF;

    // Largest number token value.
    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    localparam logic [31:0] MNEM_TEXT [MNEMONICS] = '{
        {"ADD", 8'h00}, {"SUB", 8'h00}, {"MUL", 8'h00}, {"DIV", 8'h00},
        {"MOD", 8'h00}, {"STP", 8'h00}, {"LDI", 8'h00}, {"ADR", 8'h00},
        {"SUR", 8'h00}, {"INC", 8'h00}, {"DEC", 8'h00}, {"JMP", 8'h00},
        {"CMP", 8'h00}, {"JE", 16'h0000}, {"STI", 8'h00}, {"LDM", 8'h00},
        "PUSH",         {"POP", 8'h00}
    };

    localparam logic [2:0] MNEM_LEN [MNEMONICS] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4, 3'd3
    };

    // Token class of the pending token.
    typedef enum logic [3:0] {
        TOK_NONE = 4'b0001,
        TOK_REG  = 4'b0010,
        TOK_WORD = 4'b0100,
        TOK_NUM  = 4'b1000
    } t_tok;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] slot_value;
        logic [1:0]         slot_index;
        logic               last;
        logic               too_many_tokens;
    } t_out_item;

    // Line flush from the tokenizer to the result sequencer.
    typedef struct packed {
        logic load;
        logic too_many;
    } t_flush;

    // Value of a finished word token. Unused characters of the buffer are zero,
    // as are the padding bytes of the table, so whole words are compared.
    function automatic logic [31:0] word_value(logic [31:0] chars, logic [2:0] len);
        logic [31:0] v;
        begin
            v = 32'd0;
            if (len == 3'd2 && chars == WORD_JZ) begin
                v = VALUE_JZ;
            end else if (len <= 3'(WORD_DEPTH)) begin
                // Scan downward so that the lowest matching entry wins.
                for (int i = MNEMONICS - 1; i >= 0; i--) begin
                    if (MNEM_LEN[i] == len && MNEM_TEXT[i] == chars) begin
                        v = 32'(i);
                    end
                end
            end
            return v;
        end
    endfunction

endpackage

@@ rtl/alt_core.sv @@
`timescale 1ns / 1ps

module alt_core #(
    parameter int SLOTS = alt_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  alt_pkg::t_in_item           i_item,
    output alt_pkg::t_flush             o_flush,
    output logic [SLOTS-1:0][31:0]      o_values
);
    import alt_pkg::*;

    localparam int CNTW = $clog2(SLOTS + 1);
    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_tok                  r_tok,    n_tok;
    logic [31:0]           r_word,   n_word;
    logic [2:0]            r_wlen,   n_wlen;
    logic [30:0]           r_accum,  n_accum;
    logic [1:0]            r_rdig,   n_rdig;
    logic [SLOTS-1:0][31:0] r_slots, n_slots;
    logic [CNTW-1:0]       r_count,  n_count;
    logic                  r_flag,   n_flag;

    logic [7:0]            c;
    logic                  is_upper;
    logic                  is_digit;
    logic                  is_regd;
    logic [34:0]           num_next;
    logic [31:0]           tok_value;
    logic                  finish;
    logic [SLOTS-1:0][31:0] w_slots;
    logic                  w_flag;
    logic [CNTW-1:0]       w_count;

    // Character classes.
    assign c        = i_item.ch;
    assign is_upper = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    assign is_digit = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    assign is_regd  = (c >= CH_DIGIT_0) && (c < (CH_DIGIT_0 + 8'(REGISTER_COUNT)));

    // Next decimal value: accum * 10 + digit, saturated later.
    assign num_next = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                    + {27'd0, c - CH_DIGIT_0};

    // Value of the pending token if it finishes now.
    always_comb begin
        case (r_tok)
            TOK_REG:  tok_value = (r_rdig == 2'd1) ? {1'b0, r_accum} : 32'd0;
            TOK_WORD: tok_value = word_value(r_word, r_wlen);
            TOK_NUM:  tok_value = {1'b0, r_accum};
            default:  tok_value = 32'd0;
        endcase
    end

    // Token state update and start of a new token.
    always_comb begin
        n_tok   = r_tok;
        n_word  = r_word;
        n_wlen  = r_wlen;
        n_accum = r_accum;
        n_rdig  = r_rdig;
        finish  = 1'b0;
        if (i_take) begin
            if (i_item.line_end) begin
                finish = 1'b1;
            end else if (r_tok == TOK_REG && is_regd) begin
                if (r_rdig == 2'd0) begin
                    n_accum = 31'(c - CH_DIGIT_0);
                end
                if (r_rdig < 2'd2) begin
                    n_rdig = r_rdig + 2'd1;
                end
            end else if (r_tok == TOK_WORD && is_upper) begin
                for (int k = 0; k < WORD_DEPTH; k++) begin
                    if (r_wlen == 3'(k)) begin
                        n_word[8*(WORD_DEPTH-1-k) +: 8] = c;
                    end
                end
                if (r_wlen < WORD_SAT) begin
                    n_wlen = r_wlen + 3'd1;
                end
            end else if (r_tok == TOK_NUM && is_digit) begin
                n_accum = (num_next[34:31] != 4'd0) ? NUM_MAX : num_next[30:0];
            end else begin
                finish = 1'b1;
            end

            if (finish) begin
                n_tok   = TOK_NONE;
                n_word  = 32'd0;
                n_wlen  = 3'd0;
                n_accum = 31'd0;
                n_rdig  = 2'd0;
                if (!i_item.line_end) begin
                    if (c == CH_REG) begin
                        n_tok = TOK_REG;
                    end else if (is_upper) begin
                        n_tok  = TOK_WORD;
                        n_word = {c, 24'd0};
                        n_wlen = 3'd1;
                    end else if (is_digit) begin
                        n_tok   = TOK_NUM;
                        n_accum = 31'(c - CH_DIGIT_0);
                    end
                end
            end
        end
    end

    // Slot store: a finished token goes to the next free slot or sets the flag; a line end clears them.
    always_comb begin
        w_slots = r_slots;
        w_flag  = r_flag;
        w_count = r_count;
        if (finish && r_tok != TOK_NONE) begin
            if (r_count < CNTW'(SLOTS)) begin
                w_slots[r_count[IDXW-1:0]] = tok_value;
                w_count = r_count + CNTW'(1);
            end else begin
                w_flag = 1'b1;
            end
        end
        n_slots = w_slots;
        n_flag  = w_flag;
        n_count = w_count;
        if (i_take && i_item.line_end) begin
            n_slots = '0;
            n_flag  = 1'b0;
            n_count = '0;
        end
    end

    assign o_flush.load     = i_take && i_item.line_end;
    assign o_flush.too_many = w_flag;
    assign o_values         = w_slots;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= TOK_NONE;
            r_word  <= 32'd0;
            r_wlen  <= 3'd0;
            r_accum <= 31'd0;
            r_rdig  <= 2'd0;
            r_slots <= '0;
            r_count <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_tok   <= n_tok;
            r_word  <= n_word;
            r_wlen  <= n_wlen;
            r_accum <= n_accum;
            r_rdig  <= n_rdig;
            r_slots <= n_slots;
            r_count <= n_count;
            r_flag  <= n_flag;
        end
    end

endmodule

@@ rtl/alt_emit.sv @@
`timescale 1ns / 1ps

module alt_emit #(
    parameter int SLOTS = alt_pkg::SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  alt_pkg::t_flush        i_flush,
    input  logic [SLOTS-1:0][31:0] i_values,
    output logic                   o_can_load,
    output logic                   o_valid,
    input  logic                   i_ready,
    output alt_pkg::t_out_item     o_item
);
    import alt_pkg::*;

    localparam int             IDXW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(SLOTS - 1);

    logic                   r_busy;
    logic [IDXW-1:0]        r_idx;
    logic [SLOTS-1:0][31:0] r_buf;
    logic                   r_flag;
    logic                   at_last;

    assign at_last    = (r_idx == IDX_LAST);
    assign o_can_load = !r_busy || (i_ready && at_last);

    // Control: walk through the slots, one transaction per slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_flush.load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IDXW'(1);
            end
        end
    end

    // Snapshot of the line's slot values.
    always_ff @(posedge i_clk) begin
        if (i_flush.load) begin
            r_buf  <= i_values;
            r_flag <= i_flush.too_many;
        end
    end

    assign o_valid                = r_busy;
    assign o_item.slot_value      = r_buf[r_idx];
    assign o_item.slot_index      = 2'(r_idx);
    assign o_item.last            = at_last;
    assign o_item.too_many_tokens = r_flag;

endmodule

@@ rtl/assembly_line_tokenizer.sv @@
`timescale 1ns / 1ps
// A byte is registered on acceptance and tokenized from the input register; the first result of
// a line is presented once the sequencer has taken the line's snapshot on its line end.
// Throughput: one byte per cycle while no line end waits for the sequencer; each line end yields
// SLOTS results, one per cycle from the result sequencer while the output is ready.
// Reset: synchronous, active low; clears the token state, the slots and all handshakes.

module assembly_line_tokenizer #(
    parameter int SLOTS = alt_pkg::SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  alt_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output alt_pkg::t_out_item  o_out_item
);
    import alt_pkg::*;

    logic                   r_in_valid;
    t_in_item               r_in;
    logic                   core_take;
    logic                   can_load;
    t_flush                 flush;
    logic [SLOTS-1:0][31:0] values;

    // A line end waits in the input register until the sequencer can take the line.
    assign core_take  = r_in_valid && (!r_in.line_end || can_load);
    assign o_in_ready = !r_in_valid || core_take;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    alt_core #(
        .SLOTS (SLOTS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (core_take),
        .i_item   (r_in),
        .o_flush  (flush),
        .o_values (values)
    );

    alt_emit #(
        .SLOTS (SLOTS)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flush    (flush),
        .i_values   (values),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_item)
    );

endmodule
